FILE: design/periodic_timer_min_heap_macros.svh
`ifndef PERIODIC_TIMER_MIN_HEAP_MACROS_SVH
`define PERIODIC_TIMER_MIN_HEAP_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define PTMH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define PTMH_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ptmh_pkg.sv
`timescale 1ns / 1ps

package ptmh_pkg;

   localparam int unsigned MAXRES = 16;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_STOP  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [2:0] ST_EXPIRED   = 3'd0;
   localparam logic [2:0] ST_STARTED   = 3'd1;
   localparam logic [2:0] ST_STOPPED   = 3'd2;
   localparam logic [2:0] ST_STOP_IDLE = 3'd3;
   localparam logic [2:0] ST_NONE      = 3'd4;

   localparam logic [31:0] DEFAULT_INTERVAL_RESET = 32'd1000;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  timer_id;
      logic [31:0] interval;
      logic [47:0] now;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  timer_id_res;
      logic [2:0]  status;
      logic [47:0] next_expiry;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [47:0] expiry;
      logic [3:0]  timer_id;
   } entry_type;

   function automatic logic [47:0] sat_add(input logic [47:0] now, input logic [31:0] per);
      logic [48:0] sum;
      sum = {1'b0, now} + {17'd0, per};
      return sum[48] ? TIME_MAX : sum[47:0];
   endfunction

endpackage

FILE: design/ptmh_front.sv
`timescale 1ns / 1ps

module ptmh_front #(
   parameter int unsigned TIMERS = 16
) (
   input  logic                  start,
   input  ptmh_pkg::req_item_type req_item,
   input  logic                  queue_full,
   output logic                  busy,
   output logic                  push,
   output ptmh_pkg::req_item_type push_item
);

   logic accept;
   logic id_ok;
   logic kind_ok;

   assign busy    = queue_full;
   assign accept  = start & ~queue_full;
   assign id_ok   = {24'd0, req_item.timer_id} < 28'(TIMERS);
   assign kind_ok = (req_item.kind == ptmh_pkg::KIND_TICK) ||
                    (((req_item.kind == ptmh_pkg::KIND_START) ||
                      (req_item.kind == ptmh_pkg::KIND_STOP)) && id_ok);

   // Items that cannot produce results are dropped here and never reach the queue.
   assign push      = accept & kind_ok;
   assign push_item = req_item;

endmodule

FILE: design/ptmh_cmd_fifo.sv
`timescale 1ns / 1ps

module ptmh_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ptmh_pkg::req_item_type push_item,
   input  logic                   pop,
   output logic                   empty,
   output logic                   full,
   output ptmh_pkg::req_item_type head
);

   ptmh_pkg::req_item_type slot_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] fill_ff;
   logic       do_pop;

   assign empty  = (fill_ff == 2'd0);
   assign full   = (fill_ff == 2'd2);
   assign head   = slot_ff[rd_ff];
   assign do_pop = pop & ~empty;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (do_pop) begin
            rd_ff <= ~rd_ff;
         end
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, do_pop};
      end
   end

endmodule

FILE: design/ptmh_heap_engine.sv
`timescale 1ns / 1ps

module ptmh_heap_engine #(
   parameter int unsigned TIMERS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            default_interval,
   input  logic                   cmd_empty,
   input  ptmh_pkg::req_item_type cmd_head,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   output ptmh_pkg::rsp_item_type rsp_item
);

   localparam int unsigned PW  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int unsigned CW  = $clog2(TIMERS + 1);
   localparam int unsigned LW  = PW + 2;
   localparam int unsigned NID = (TIMERS < 16) ? TIMERS : 16;
   localparam int unsigned IW  = $clog2(NID);

   typedef enum logic [3:0] {
      S_IDLE, S_RM, S_RM_LD, S_UP_RD, S_UP_CMP, S_DN_L, S_DN_R, S_DN_SEL,
      S_PLACE, S_INS, S_EMIT, S_TPEEK, S_TCHK, S_TEND
   } state_type;

   typedef enum logic [1:0] {
      R_INSERT, R_EMIT, R_TICK
   } ret_type;

   state_type              state_ff;
   ret_type                ret_ff;
   ptmh_pkg::req_item_type cmd_ff;
   logic [31:0]            period_ff [NID];
   logic [PW-1:0]          pos_ff    [NID];
   logic                   valid_ff  [NID];
   logic [CW-1:0]          count_ff;
   logic [PW-1:0]          idx_ff;
   logic                   first_ff;
   ptmh_pkg::entry_type    cur_ff;
   ptmh_pkg::entry_type    left_ff;
   logic                   has_r_ff;
   logic [3:0]             rm_id_ff;
   logic [3:0]             ins_id_ff;
   logic [4:0]             n_ff;
   logic [3:0]             k_ff;
   logic [3:0]             popped_ff [ptmh_pkg::MAXRES];
   logic                   rsp_valid_ff;
   ptmh_pkg::rsp_item_type rsp_item_ff;

   ptmh_pkg::entry_type    mem [TIMERS];
   ptmh_pkg::entry_type    rd_data_ff;
   logic [PW-1:0]          rd_addr;
   logic                   mem_we;
   logic [PW-1:0]          mem_wa;
   ptmh_pkg::entry_type    mem_wd;

   logic [PW-1:0]          pidx;
   logic [LW-1:0]          l_w;
   logic [LW-1:0]          r_w;
   logic [LW-1:0]          cnt_l;
   logic [PW-1:0]          rpos;
   logic                   pick_r;
   ptmh_pkg::entry_type    child;
   logic [PW-1:0]          cidx;
   logic                   tick_last;
   state_type              cont;

   assign pidx      = PW'((idx_ff - PW'(1)) >> 1);
   assign l_w       = {1'b0, idx_ff, 1'b1};
   assign r_w       = l_w + LW'(1);
   assign cnt_l     = LW'(count_ff);
   assign rpos      = pos_ff[rm_id_ff[IW-1:0]];
   assign pick_r    = has_r_ff && !(left_ff.expiry < rd_data_ff.expiry);
   assign child     = pick_r ? rd_data_ff : left_ff;
   assign cidx      = pick_r ? PW'(r_w) : PW'(l_w);
   assign tick_last = (({1'b0, k_ff} + 5'd1) == n_ff);
   assign cmd_pop   = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      case (ret_ff)
         R_INSERT: cont = S_INS;
         R_EMIT:   cont = S_EMIT;
         R_TICK:   cont = S_TPEEK;
         default:  cont = S_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         S_RM:    rd_addr = PW'(count_ff - CW'(1));
         S_UP_RD: rd_addr = pidx;
         S_DN_L:  rd_addr = PW'(l_w);
         S_DN_R:  rd_addr = PW'(r_w);
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = cur_ff;
      case (state_ff)
         S_UP_CMP: begin
            mem_we = (cur_ff.expiry < rd_data_ff.expiry);
            mem_wd = rd_data_ff;
         end
         S_DN_SEL: begin
            mem_we = !(cur_ff.expiry < child.expiry);
            mem_wd = child;
         end
         S_PLACE: begin
            mem_we = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= R_EMIT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NID; i++) begin
            valid_ff[i]  <= 1'b0;
            period_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff <= cmd_head;
                  case (cmd_head.kind)
                     ptmh_pkg::KIND_START: begin
                        period_ff[cmd_head.timer_id[IW-1:0]] <=
                           (cmd_head.interval != 32'd0) ? cmd_head.interval : default_interval;
                        ins_id_ff <= cmd_head.timer_id;
                        rm_id_ff  <= cmd_head.timer_id;
                        ret_ff    <= R_INSERT;
                        state_ff  <= valid_ff[cmd_head.timer_id[IW-1:0]] ? S_RM : S_INS;
                     end
                     ptmh_pkg::KIND_STOP: begin
                        rm_id_ff <= cmd_head.timer_id;
                        ret_ff   <= R_EMIT;
                        if (valid_ff[cmd_head.timer_id[IW-1:0]]) begin
                           state_ff <= S_RM;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           rsp_item_ff  <= '{timer_id_res: cmd_head.timer_id,
                                             status: ptmh_pkg::ST_STOP_IDLE,
                                             next_expiry: 48'd0, last: 1'b1};
                        end
                     end
                     ptmh_pkg::KIND_TICK: begin
                        n_ff     <= '0;
                        state_ff <= S_TPEEK;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_RM: begin
               valid_ff[rm_id_ff[IW-1:0]] <= 1'b0;
               idx_ff   <= rpos;
               count_ff <= count_ff - CW'(1);
               state_ff <= (CW'(rpos) == (count_ff - CW'(1))) ? cont : S_RM_LD;
            end
            S_RM_LD: begin
               cur_ff   <= rd_data_ff;
               first_ff <= 1'b1;
               state_ff <= (idx_ff == '0) ? S_DN_L : S_UP_RD;
            end
            S_UP_RD: begin
               state_ff <= (idx_ff == '0) ? S_PLACE : S_UP_CMP;
            end
            S_UP_CMP: begin
               if (cur_ff.expiry < rd_data_ff.expiry) begin
                  pos_ff[rd_data_ff.timer_id[IW-1:0]] <= idx_ff;
                  idx_ff   <= pidx;
                  first_ff <= 1'b0;
                  state_ff <= S_UP_RD;
               end else begin
                  first_ff <= 1'b0;
                  state_ff <= first_ff ? S_DN_L : S_PLACE;
               end
            end
            S_DN_L: begin
               state_ff <= (l_w >= cnt_l) ? S_PLACE : S_DN_R;
            end
            S_DN_R: begin
               left_ff  <= rd_data_ff;
               has_r_ff <= (r_w < cnt_l);
               state_ff <= S_DN_SEL;
            end
            S_DN_SEL: begin
               if (cur_ff.expiry < child.expiry) begin
                  state_ff <= S_PLACE;
               end else begin
                  pos_ff[child.timer_id[IW-1:0]] <= idx_ff;
                  idx_ff   <= cidx;
                  state_ff <= S_DN_L;
               end
            end
            S_PLACE: begin
               pos_ff[cur_ff.timer_id[IW-1:0]] <= idx_ff;
               state_ff <= cont;
            end
            S_INS: begin
               cur_ff.expiry   <= ptmh_pkg::sat_add(cmd_ff.now, period_ff[ins_id_ff[IW-1:0]]);
               cur_ff.timer_id <= ins_id_ff;
               valid_ff[ins_id_ff[IW-1:0]] <= 1'b1;
               idx_ff   <= PW'(count_ff);
               count_ff <= count_ff + CW'(1);
               first_ff <= 1'b0;
               ret_ff   <= R_EMIT;
               state_ff <= S_UP_RD;
            end
            S_EMIT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
               case (cmd_ff.kind)
                  ptmh_pkg::KIND_START: begin
                     rsp_item_ff <= '{timer_id_res: cmd_ff.timer_id,
                                      status: ptmh_pkg::ST_STARTED,
                                      next_expiry: cur_ff.expiry, last: 1'b1};
                  end
                  ptmh_pkg::KIND_STOP: begin
                     rsp_item_ff <= '{timer_id_res: cmd_ff.timer_id,
                                      status: ptmh_pkg::ST_STOPPED,
                                      next_expiry: 48'd0, last: 1'b1};
                  end
                  default: begin
                     rsp_item_ff <= '{timer_id_res: cur_ff.timer_id,
                                      status: ptmh_pkg::ST_EXPIRED,
                                      next_expiry: cur_ff.expiry, last: tick_last};
                     if (!tick_last) begin
                        k_ff      <= k_ff + 4'd1;
                        ins_id_ff <= popped_ff[k_ff + 4'd1];
                        state_ff  <= S_INS;
                     end
                  end
               endcase
            end
            S_TPEEK: begin
               state_ff <= ((n_ff < 5'(ptmh_pkg::MAXRES)) && (count_ff != '0)) ? S_TCHK : S_TEND;
            end
            S_TCHK: begin
               if (rd_data_ff.expiry <= cmd_ff.now) begin
                  popped_ff[n_ff[3:0]] <= rd_data_ff.timer_id;
                  n_ff     <= n_ff + 5'd1;
                  rm_id_ff <= rd_data_ff.timer_id;
                  ret_ff   <= R_TICK;
                  state_ff <= S_RM;
               end else begin
                  state_ff <= S_TEND;
               end
            end
            S_TEND: begin
               if (n_ff == 5'd0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_item_ff  <= '{timer_id_res: 4'd0, status: ptmh_pkg::ST_NONE,
                                    next_expiry: 48'd0, last: 1'b1};
                  state_ff     <= S_IDLE;
               end else begin
                  k_ff      <= 4'd0;
                  ins_id_ff <= popped_ff[0];
                  state_ff  <= S_INS;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: design/periodic_timer_min_heap.sv
`timescale 1ns / 1ps
// Channel    Handshake           Payload
// request    start / busy        req_item
// response   rsp_valid strobe    rsp_item
// register   APB write/read      pwdata / prdata
// Accepted transfers with a valid kind and timer id pass through the two-entry command queue.
// Once taken from the queue, a start, or a stop of a running timer, updates the heap before its result;
// the heap sequencer reads one entry per step over at most four levels.
// A tick with nothing due gives a single none result; otherwise each expired timer is re-armed and reported.
// Reset is synchronous and empties the heap; busy is high while the command queue is full.
// Each result is shown for one cycle and cannot be held off.

module periodic_timer_min_heap #(
   parameter int unsigned TIMERS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ptmh_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output ptmh_pkg::rsp_item_type rsp_item,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic                   cfg_write;
   logic [31:0]            dflt_ff;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_push;
   logic                   q_pop;
   ptmh_pkg::req_item_type q_in;
   ptmh_pkg::req_item_type q_head;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? dflt_ff : 32'd0;
   assign cfg_write = psel & penable & pwrite & (paddr[2] == 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_ff <= ptmh_pkg::DEFAULT_INTERVAL_RESET;
      end else if (cfg_write) begin
         dflt_ff <= pwdata;
      end
   end

   ptmh_front #(.TIMERS(TIMERS)) u_front (
      .start      (start),
      .req_item   (req_item),
      .queue_full (q_full),
      .busy       (busy),
      .push       (q_push),
      .push_item  (q_in)
   );

   ptmh_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in),
      .pop       (q_pop),
      .empty     (q_empty),
      .full      (q_full),
      .head      (q_head)
   );

   ptmh_heap_engine #(.TIMERS(TIMERS)) u_engine (
      .clock            (clock),
      .reset            (reset),
      .default_interval (dflt_ff),
      .cmd_empty        (q_empty),
      .cmd_head         (q_head),
      .cmd_pop          (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item)
   );

endmodule

FILE: design/ptmh_checker.sv
`timescale 1ns / 1ps
`include "periodic_timer_min_heap_macros.svh"

module ptmh_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   busy,
   input logic                   rsp_valid,
   input ptmh_pkg::rsp_item_type rsp_item,
   input logic                   pready
);

   `PTMH_ASSERT_IMP(a_pready_high, clock, reset, 1'b1, pready, "pready must stay high")
   `PTMH_ASSERT_IMP(a_idle_results, clock, reset,
      rsp_valid && ((rsp_item.status == ptmh_pkg::ST_STOP_IDLE) ||
                    (rsp_item.status == ptmh_pkg::ST_NONE) ||
                    (rsp_item.status == ptmh_pkg::ST_STOPPED)),
      (rsp_item.next_expiry == 48'd0) && rsp_item.last, "stop or empty tick result malformed")
   `PTMH_ASSERT_IMP(a_start_last, clock, reset,
      rsp_valid && (rsp_item.status == ptmh_pkg::ST_STARTED), rsp_item.last,
      "start result must be the final one")
   `PTMH_ASSERT_NXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !busy,
      "block not quiet after reset")

endmodule

bind periodic_timer_min_heap ptmh_checker u_ptmh_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item),
   .pready    (pready)
);
